// File: rtl/terminal_key_decoder_cursor_assert.svh
// Assertion macros shared by the terminal key decoder modules
`ifndef TERMINAL_KEY_DECODER_CURSOR_ASSERT_SVH
`define TERMINAL_KEY_DECODER_CURSOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tkd_pkg.sv
// Shared types and constants for the terminal key decoder
package tkd_pkg;

  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int KEY_W   = 9;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef logic [7:0]       byte_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CFG_W-1:0] cfg_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 1'b1;

  localparam cfg_t ROWS_RESET = 11'd24;
  localparam cfg_t COLS_RESET = 11'd80;

  // Terminal bytes
  localparam byte_t CH_ESC      = 8'h1b;
  localparam byte_t CH_LBRACKET = 8'h5b;
  localparam byte_t CH_O        = 8'h4f;
  localparam byte_t CH_TILDE    = 8'h7e;
  localparam byte_t CTRL_MASK   = 8'h1f;

  // Key codes
  localparam key_t K_ESC    = 9'(CH_ESC);
  localparam key_t K_CTRL_Q = 9'(8'h71 & CTRL_MASK);
  localparam key_t K_LEFT   = 9'd256;
  localparam key_t K_RIGHT  = 9'd257;
  localparam key_t K_UP     = 9'd258;
  localparam key_t K_DOWN   = 9'd259;
  localparam key_t K_DEL    = 9'd260;
  localparam key_t K_HOME   = 9'd261;
  localparam key_t K_END    = 9'd262;
  localparam key_t K_PGUP   = 9'd263;
  localparam key_t K_PGDN   = 9'd264;

  // One decoded key moving between front end, queue and cursor unit
  typedef struct packed {
    logic valid;
    key_t key;
  } key_xfer_t;

endpackage

// File: rtl/terminal_key_decoder_cursor.sv
// Terminal key decoder: turns terminal bytes and read timeouts into keys and a
// clamped cursor position. The parser accepts one transaction per clock while
// in_stall is low and feeds a two-entry key queue; the cursor unit drains one key
// per clock into the result register while the result is not stalled, so the
// sustained rate is one transaction per cycle when neither side stalls.
// A key that a transaction completes is written into the key queue and then into
// the result register, which drives the result port. in_stall rises only while
// the key queue is full. Screen size registers should be written while no transaction is in flight.
module terminal_key_decoder_cursor #(
  parameter int COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [tkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  tkd_pkg::cfg_t                  cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  tkd_pkg::byte_t                 in_in_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output tkd_pkg::key_t                  out_key_code,
  output logic [COORD_BITS-1:0]          out_cursor_col,
  output logic [COORD_BITS-1:0]          out_cursor_row,
  output logic                           out_quit
);
  import tkd_pkg::*;

  cfg_t      rows_r;
  cfg_t      cols_r;
  key_xfer_t push;
  key_xfer_t head;
  logic      q_full;
  logic      pop;
  logic      accept;

  // Screen size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_ROWS: rows_r <= cfg_data;
        REG_SCREEN_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  tkd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (in_cmd),
    .in_byte (in_in_byte),
    .push    (push)
  );

  tkd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  tkd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .screen_rows    (rows_r),
    .screen_cols    (cols_r),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_quit       (out_quit)
  );

endmodule

// File: rtl/tkd_front.sv
// Front end: escape-sequence parser that turns bytes and timeouts into keys
module tkd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              cmd,
  input  tkd_pkg::byte_t    in_byte,
  output tkd_pkg::key_xfer_t push
);
  import tkd_pkg::*;

  `include "terminal_key_decoder_cursor_assert.svh"

  typedef enum logic [1:0] {
    IDLE,
    GOT_ESC,
    GOT_FIRST,
    GOT_SECOND
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  first_r, first_nxt;
  byte_t  second_r, second_nxt;

  // Two-byte sequences: ESC [ x and ESC O x
  function automatic key_t decode_two(byte_t a, byte_t b);
    key_t k;
    k = K_ESC;
    if (a == CH_LBRACKET) begin
      case (b)
        "A":     k = K_UP;
        "B":     k = K_DOWN;
        "C":     k = K_RIGHT;
        "D":     k = K_LEFT;
        "H":     k = K_HOME;
        "F":     k = K_END;
        default: k = K_ESC;
      endcase
    end else if (a == CH_O) begin
      case (b)
        "H":     k = K_HOME;
        "F":     k = K_END;
        default: k = K_ESC;
      endcase
    end
    return k;
  endfunction

  // Three-byte sequences: ESC [ digit ~
  function automatic key_t decode_three(byte_t digit, byte_t last);
    key_t k;
    k = K_ESC;
    if (last == CH_TILDE) begin
      case (digit)
        "1", "7": k = K_HOME;
        "3":      k = K_DEL;
        "4", "8": k = K_END;
        "5":      k = K_PGUP;
        "6":      k = K_PGDN;
        default:  k = K_ESC;
      endcase
    end
    return k;
  endfunction

  // Next phase and key push for the accepted transaction
  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    push.valid = 1'b0;
    push.key   = K_ESC;
    if (accept) begin
      if (cmd) begin
        // timeout: a pending sequence collapses to ESC
        phase_nxt  = IDLE;
        push.valid = (phase_r != IDLE);
        push.key   = K_ESC;
      end else begin
        case (phase_r)
          IDLE: begin
            if (in_byte == CH_ESC) begin
              phase_nxt = GOT_ESC;
            end else begin
              push.valid = 1'b1;
              push.key   = 9'(in_byte);
            end
          end
          GOT_ESC: begin
            first_nxt = in_byte;
            phase_nxt = GOT_FIRST;
          end
          GOT_FIRST: begin
            second_nxt = in_byte;
            if (first_r == CH_LBRACKET && in_byte inside {["0":"9"]}) begin
              phase_nxt = GOT_SECOND;
            end else begin
              phase_nxt  = IDLE;
              push.valid = 1'b1;
              push.key   = decode_two(first_r, in_byte);
            end
          end
          GOT_SECOND: begin
            phase_nxt  = IDLE;
            push.valid = 1'b1;
            push.key   = decode_three(second_r, in_byte);
          end
          default: phase_nxt = IDLE;
        endcase
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= IDLE;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  `TKD_ASSERT_IMP(a_seq3_lb, phase_r == GOT_SECOND, first_r == CH_LBRACKET, "missing [")
  `TKD_ASSERT_IMP(a_push_needs_accept, push.valid, accept, "push without transaction")

endmodule

// File: rtl/tkd_queue.sv
// Short key queue between the parser and the cursor unit
module tkd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tkd_pkg::key_xfer_t push,
  output logic               full,
  input  logic               pop,
  output tkd_pkg::key_xfer_t head
);
  import tkd_pkg::*;

  `include "terminal_key_decoder_cursor_assert.svh"

  key_t            entries_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign full       = (count_r == Q_CW'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.key   = entries_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(push.valid) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wr_ptr_r] <= push.key;
    end
  end

  `TKD_ASSERT_IMP(a_no_push_when_full, push.valid, !full, "push into a full key queue")
  `TKD_ASSERT_IMP(a_no_pop_when_empty, pop, count_r != '0, "pop from an empty key queue")

endmodule

// File: rtl/tkd_back.sv
// Back end: applies keys to the clamped cursor and holds the result register
module tkd_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tkd_pkg::cfg_t         screen_rows,
  input  tkd_pkg::cfg_t         screen_cols,
  input  tkd_pkg::key_xfer_t    head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tkd_pkg::key_t         out_key_code,
  output logic [COORD_BITS-1:0] out_cursor_col,
  output logic [COORD_BITS-1:0] out_cursor_row,
  output logic                  out_quit
);
  import tkd_pkg::*;

  `include "terminal_key_decoder_cursor_assert.svh"

  localparam int EXT_W = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam logic [EXT_W-1:0] LIMIT = EXT_W'(1) << COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  coord_t col_r, col_nxt;
  coord_t row_r, row_nxt;
  coord_t last_col, last_row;
  logic   out_valid_r;
  key_t   key_r;
  logic   quit_r;

  // Last usable index: size 0 acts as 1, sizes above the coordinate range saturate
  function automatic coord_t last_index(cfg_t v);
    logic [EXT_W-1:0] v_ext;
    coord_t           r;
    v_ext = EXT_W'(v);
    if (v_ext == '0) begin
      r = '0;
    end else if (v_ext >= LIMIT) begin
      r = '1;
    end else begin
      r = COORD_BITS'(v_ext - EXT_W'(1));
    end
    return r;
  endfunction

  assign last_col = last_index(screen_cols);
  assign last_row = last_index(screen_rows);

  // Take the next key whenever the result register is free or draining
  assign pop = head.valid && (!out_valid_r || !out_stall);

  // Cursor movement
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (head.key)
      K_LEFT:  col_nxt = (col_r != '0) ? col_r - 1'b1 : col_r;
      K_RIGHT: col_nxt = (col_r >= last_col) ? last_col : col_r + 1'b1;
      K_UP:    row_nxt = (row_r != '0) ? row_r - 1'b1 : row_r;
      K_DOWN:  row_nxt = (row_r >= last_row) ? last_row : row_r + 1'b1;
      K_HOME:  col_nxt = '0;
      K_END:   col_nxt = last_col;
      K_PGUP:  row_nxt = '0;
      K_PGDN:  row_nxt = last_row;
      default: ;
    endcase
  end

  // Cursor and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      key_r  <= head.key;
      quit_r <= (head.key == K_CTRL_Q);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = key_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_quit       = quit_r;

  `TKD_ASSERT_NXT(a_pop_fills_result, pop, out_valid_r, "popped key lost")
  `TKD_ASSERT_NXT(a_cursor_hold, !pop, $stable(col_r) && $stable(row_r), "cursor moved")

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the terminal key decoder with cursor tracking
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  localparam int COORD_BITS      = 10;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES      = 8;
  localparam int SETTLE_CYCLES   = 4;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {PS_IDLE, PS_FIRST, PS_SECOND, PS_THIRD} parse_st_t;

  typedef struct packed {
    logic  cmd;
    byte_t b;
  } term_item_t;

  typedef struct packed {
    key_t   key;
    coord_t col;
    coord_t row;
    logic   quit;
  } key_res_t;

  typedef struct packed {
    term_item_t item;
    bit         fixed;
    key_res_t   want;
  } dir_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_ROWS;
  cfg_t   cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_cmd = 1'b0;
  byte_t  in_in_byte = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  key_t   out_key_code;
  coord_t out_cursor_col;
  coord_t out_cursor_row;
  logic   out_quit;

  terminal_key_decoder_cursor #(.COORD_BITS(COORD_BITS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_in_byte     (in_in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_code   (out_key_code),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_quit       (out_quit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, mirrors the decoder after every accepted transaction
  parse_st_t parse_st = PS_IDLE;
  byte_t     seq_b1 = '0;
  byte_t     seq_b2 = '0;
  coord_t    cur_col = '0;
  coord_t    cur_row = '0;
  cfg_t      scr_rows = ROWS_RESET;
  cfg_t      scr_cols = COLS_RESET;

  key_res_t   exp_keys[$];
  term_item_t burst_q[$];
  dir_row_t   dir_tab[$];
  int         err_cnt = 0;
  int         taken_cnt = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  task automatic flag_mismatch(input string msg);
    if (err_cnt < 40) $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Last valid index for a screen size register, with out-of-range sizes clamped
  function automatic coord_t last_index(input cfg_t v);
    cfg_t t;
    if (v == 0) return '0;
    if (v > (1 << COORD_BITS)) return {COORD_BITS{1'b1}};
    t = v - 1'b1;
    return t[COORD_BITS-1:0];
  endfunction

  // Predict the key (if any) caused by one transaction and move the cursor
  function automatic bit decode_key(input logic c, input byte_t b, output key_res_t r);
    key_t   k;
    coord_t lc;
    coord_t lr;
    r  = '0;
    k  = K_ESC;
    lc = last_index(scr_cols);
    lr = last_index(scr_rows);
    if (c) begin
      // timeout: ignored when idle, flushes a pending sequence as ESC
      if (parse_st == PS_IDLE) return 1'b0;
      parse_st = PS_IDLE;
    end else begin
      case (parse_st)
        PS_IDLE: begin
          if (b == CH_ESC) begin
            parse_st = PS_FIRST;
            return 1'b0;
          end
          k = key_t'(b);
        end
        PS_FIRST: begin
          seq_b1   = b;
          parse_st = PS_SECOND;
          return 1'b0;
        end
        PS_SECOND: begin
          seq_b2 = b;
          if (seq_b1 == CH_LBRACKET && b >= "0" && b <= "9") begin
            parse_st = PS_THIRD;
            return 1'b0;
          end
          parse_st = PS_IDLE;
          if (seq_b1 == CH_LBRACKET) begin
            case (b)
              "A": k = K_UP;
              "B": k = K_DOWN;
              "C": k = K_RIGHT;
              "D": k = K_LEFT;
              "H": k = K_HOME;
              "F": k = K_END;
              default: k = K_ESC;
            endcase
          end else if (seq_b1 == CH_O) begin
            if (b == "H") k = K_HOME;
            else if (b == "F") k = K_END;
          end
        end
        default: begin
          parse_st = PS_IDLE;
          if (b == CH_TILDE) begin
            case (seq_b2)
              "1", "7": k = K_HOME;
              "3":      k = K_DEL;
              "4", "8": k = K_END;
              "5":      k = K_PGUP;
              "6":      k = K_PGDN;
              default:  k = K_ESC;
            endcase
          end
        end
      endcase
    end

    // cursor moves saturate at the screen edge
    case (k)
      K_LEFT:  if (cur_col != 0) cur_col = cur_col - 1'b1;
      K_RIGHT: cur_col = (cur_col >= lc) ? lc : cur_col + 1'b1;
      K_UP:    if (cur_row != 0) cur_row = cur_row - 1'b1;
      K_DOWN:  cur_row = (cur_row >= lr) ? lr : cur_row + 1'b1;
      K_HOME:  cur_col = '0;
      K_END:   cur_col = lc;
      K_PGUP:  cur_row = '0;
      K_PGDN:  cur_row = lr;
      default: ;
    endcase
    r.key  = k;
    r.col  = cur_col;
    r.row  = cur_row;
    r.quit = (k == K_CTRL_Q);
    return 1'b1;
  endfunction

  // Drive one transaction, wait for acceptance, then record its expected key
  task automatic send_item(input logic c, input byte_t b, input bit fixed,
                           input key_res_t want);
    key_res_t res;
    bit       has;
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(c && parse_st == PS_IDLE)) taken_cnt++;
    has = decode_key(c, b, res);
    if (fixed) exp_keys.push_back(want);
    else if (has) exp_keys.push_back(res);
  endtask

  // Random sender gap after a transaction
  task automatic idle_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Hold the sender off until every pending key has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (exp_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both screen size registers, decoder idle
  task automatic write_screen(input cfg_t rows, input cfg_t cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_SCREEN_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scr_rows = rows;
    scr_cols = cols;
  endtask

  function automatic void tab_add(input logic c, input byte_t b, input bit fx,
                                  input key_t k, input coord_t col, input coord_t row,
                                  input logic q);
    dir_row_t d;
    d.item.cmd  = c;
    d.item.b    = b;
    d.fixed     = fx;
    d.want.key  = k;
    d.want.col  = col;
    d.want.row  = row;
    d.want.quit = q;
    dir_tab.push_back(d);
  endfunction

  // ESC followed by the given bytes, all checked against the predictor
  function automatic void tab_esc(input string s);
    tab_add(1'b0, CH_ESC, 1'b0, '0, '0, '0, 1'b0);
    for (int i = 0; i < s.len(); i++) tab_add(1'b0, s[i], 1'b0, '0, '0, '0, 1'b0);
  endfunction

  function automatic void burst_add(input logic c, input byte_t b);
    term_item_t t;
    t.cmd = c;
    t.b   = b;
    burst_q.push_back(t);
  endfunction

  // One random burst: well-formed sequences, some broken ones and noise
  task automatic fill_burst();
    string arw;
    string dig;
    int    kind;
    int    sel;
    arw  = "ABCDHFHF";
    dig  = "1345678";
    kind = $urandom_range(99);
    if (kind < 40) begin
      sel = $urandom_range(14);
      burst_add(1'b0, CH_ESC);
      if (sel < 8) begin
        burst_add(1'b0, (sel < 6) ? CH_LBRACKET : CH_O);
        burst_add(1'b0, arw[sel]);
      end else begin
        burst_add(1'b0, CH_LBRACKET);
        burst_add(1'b0, dig[sel-8]);
        burst_add(1'b0, CH_TILDE);
      end
    end else if (kind < 55) begin
      burst_add(1'b0, byte_t'($urandom_range(255)));
    end else if (kind < 60) begin
      burst_add(1'b0, K_CTRL_Q[7:0]);
    end else if (kind < 70) begin
      burst_add(1'b0, CH_ESC);
      burst_add(1'b0, CH_LBRACKET);
      burst_add(1'b0, byte_t'("0" + $urandom_range(9)));
      burst_add(1'b0, ($urandom_range(1) != 0) ? CH_TILDE : byte_t'($urandom_range(255)));
    end else if (kind < 78) begin
      burst_add(1'b0, CH_ESC);
      burst_add(1'b0, byte_t'($urandom_range(255)));
      burst_add(1'b0, byte_t'($urandom_range(255)));
    end else if (kind < 82) begin
      // ESC inside a sequence is just another sequence byte
      burst_add(1'b0, CH_ESC);
      burst_add(1'b0, CH_ESC);
      burst_add(1'b0, ($urandom_range(1) != 0) ? CH_ESC : byte_t'($urandom_range(255)));
    end else if (kind < 92) begin
      // sequence cut short by a read timeout
      sel = $urandom_range(2);
      burst_add(1'b0, CH_ESC);
      if (sel >= 1) burst_add(1'b0, CH_LBRACKET);
      if (sel >= 2) burst_add(1'b0, byte_t'("0" + $urandom_range(9)));
      burst_add(1'b1, byte_t'($urandom_range(255)));
    end else begin
      burst_add(1'b1, byte_t'($urandom_range(255)));
    end
  endtask

  // Result check and receiver stall
  always @(posedge clk) begin : result_check
    key_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_keys.size() == 0) begin
        flag_mismatch($sformatf("unexpected key %0d", out_key_code));
      end else begin
        want = exp_keys.pop_front();
        if (out_key_code !== want.key)
          flag_mismatch($sformatf("key_code %0d, want %0d", out_key_code, want.key));
        if (out_cursor_col !== want.col)
          flag_mismatch($sformatf("cursor_col %0d, want %0d", out_cursor_col, want.col));
        if (out_cursor_row !== want.row)
          flag_mismatch($sformatf("cursor_row %0d, want %0d", out_cursor_row, want.row));
        if (out_quit !== want.quit)
          flag_mismatch($sformatf("quit %0b, want %0b", out_quit, want.quit));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Main stimulus
  initial begin : stim
    term_item_t it;
    key_res_t   no_res;
    int         start;
    bit         paused;
    no_res = '0;
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset screen of 24 rows by 80 columns
    tab_add(1'b0, 8'h00, 1'b1, 9'd0, 0, 0, 1'b0);
    tab_add(1'b0, 8'hff, 1'b1, 9'd255, 0, 0, 1'b0);
    tab_add(1'b1, 8'h00, 1'b0, '0, 0, 0, 1'b0);
    tab_add(1'b0, K_CTRL_Q[7:0], 1'b1, K_CTRL_Q, 0, 0, 1'b1);
    tab_esc("[");
    tab_add(1'b0, "A", 1'b1, K_UP, 0, 0, 1'b0);
    tab_esc("[");
    tab_add(1'b0, "F", 1'b1, K_END, 79, 0, 1'b0);
    tab_esc("[");
    tab_add(1'b0, "C", 1'b1, K_RIGHT, 79, 0, 1'b0);
    tab_esc("OH");
    tab_esc("[");
    tab_add(1'b0, "D", 1'b1, K_LEFT, 0, 0, 1'b0);
    tab_esc("[6");
    tab_add(1'b0, CH_TILDE, 1'b1, K_PGDN, 0, 23, 1'b0);
    tab_esc("[3~");
    tab_esc("");
    tab_add(1'b1, 8'hff, 1'b1, K_ESC, 0, 23, 1'b0);
    tab_esc("\033\033");
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item.cmd, dir_tab[i].item.b, dir_tab[i].fixed,
                dir_tab[i].want);
    end

    // Random phases; phases 1 to 7 write a new screen size, and the idling pattern cycles through four settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        1: write_screen(11'd1, 11'd1);
        2: write_screen(11'd1024, 11'd1024);
        3: write_screen(11'd5, 11'd7);
        4: write_screen(11'd0, 11'd0);
        5: write_screen(11'd2047, 11'd1025);
        6: write_screen(cfg_t'($urandom_range(64, 1)), cfg_t'($urandom_range(100, 1)));
        7: write_screen(cfg_t'($urandom_range(2047)), cfg_t'($urandom_range(2047)));
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      start = taken_cnt;
      while (taken_cnt - start < ITEMS_PER_PHASE) begin
        fill_burst();
        while (burst_q.size() != 0) begin
          it = burst_q.pop_front();
          send_item(it.cmd, it.b, 1'b0, no_res);
          idle_gap();
        end
        if (p == 5 && !paused && taken_cnt - start >= ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          drain_results();
        end
      end
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("terminal_key_decoder_cursor: match");
    end else begin
      $display("terminal_key_decoder_cursor: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("terminal_key_decoder_cursor: mismatch");
    $finish;
  end

endmodule
